// ===== rtl/swm_pkg.sv =====
// Shared types, sizes and helpers for the sliding-window median filter.
// Used by every module under rtl; depends on nothing else.
package swm_pkg;

    // Window depth and sample width
    localparam int WINDOW_MAX  = 16;
    localparam int SAMPLE_BITS = 32;

    // Derived sizes
    localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int RES_BITS  = SAMPLE_BITS + 1;
    localparam int S_TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    // Window size register
    localparam int             CFG_W     = 5;
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [RES_BITS-1:0]    result_t;
    typedef logic [CNT_W-1:0]              cnt_t;
    typedef logic [IDX_W-1:0]              idx_t;

    // Handshake status from the result stage back to the window stage
    typedef struct packed {
        logic ready;   // window may advance this cycle
    } med_status_t;

    // Map the raw register value to a window length in 1..WINDOW_MAX
    function automatic cnt_t eff_size(input logic [CFG_W-1:0] cfg);
        cnt_t k;
        if (cfg == '0) begin
            k = cnt_t'(1);
        end else if (int'(cfg) > WINDOW_MAX) begin
            k = cnt_t'(WINDOW_MAX);
        end else begin
            k = cnt_t'(cfg);
        end
        return k;
    endfunction

endpackage

// ===== rtl/swm_window.sv =====
// Window state of the median filter: arrival shift line, sorted list, fill count.
// One insert (and one removal when full) per update, done with parallel compares.
// Depends on swm_pkg.
module swm_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  swm_pkg::cnt_t     win_k,
    input  logic              upd_en,
    input  swm_pkg::sample_t  sample,
    output logic              emit,
    output swm_pkg::sample_t  sorted_o [swm_pkg::WINDOW_MAX]
);

    localparam int N = swm_pkg::WINDOW_MAX;

    swm_pkg::sample_t hist_reg   [N];
    swm_pkg::sample_t hist_next  [N];
    swm_pkg::sample_t sorted_reg [N];
    swm_pkg::sample_t sorted_next[N];
    swm_pkg::sample_t rem        [N];
    swm_pkg::cnt_t    fill_reg;
    swm_pkg::cnt_t    fill_next;
    swm_pkg::cnt_t    rem_cnt;
    swm_pkg::sample_t oldest;
    swm_pkg::idx_t    oldest_idx;
    logic             full;
    logic [N-1:0]     le;
    logic [N-1:0]     keep;
    logic [N-1:0]     rem_le;

    assign full       = (fill_reg == win_k);
    assign oldest_idx = swm_pkg::idx_t'(win_k - swm_pkg::cnt_t'(1));
    assign oldest     = hist_reg[oldest_idx];
    assign rem_cnt    = full ? (win_k - swm_pkg::cnt_t'(1)) : fill_reg;
    assign fill_next  = full ? win_k : (fill_reg + swm_pkg::cnt_t'(1));
    assign emit       = (fill_next == win_k);

    // Shift the new sample into the arrival line; the oldest sits at k-1
    always_comb begin
        hist_next[0] = sample;
        for (int i = 1; i < N; i++) begin
            hist_next[i] = hist_reg[i-1];
        end
    end

    // Drop one copy of the oldest value: entries below it stay, the rest close up
    always_comb begin
        for (int i = 0; i < N; i++) begin
            le[i]   = (sorted_reg[i] <= sample);
            keep[i] = !full || (sorted_reg[i] < oldest);
        end
        for (int i = 0; i < N; i++) begin
            if (keep[i] || i == N - 1) begin
                rem[i] = sorted_reg[i];
            end else begin
                rem[i] = sorted_reg[(i + 1) % N];
            end
        end
        for (int i = 0; i < N; i++) begin
            if (swm_pkg::cnt_t'(i) < rem_cnt) begin
                if (keep[i] || i == N - 1) begin
                    rem_le[i] = le[i];
                end else begin
                    rem_le[i] = le[(i + 1) % N];
                end
            end else begin
                rem_le[i] = 1'b0;
            end
        end
    end

    // Insert the new sample after every entry not above it
    always_comb begin
        for (int i = 0; i < N; i++) begin
            if (rem_le[i]) begin
                sorted_next[i] = rem[i];
            end else if (i == 0) begin
                sorted_next[i] = sample;
            end else if (rem_le[(i + N - 1) % N]) begin
                sorted_next[i] = sample;
            end else begin
                sorted_next[i] = rem[(i + N - 1) % N];
            end
        end
    end

    // Window contents; fill count alone marks what is valid
    always_ff @(posedge aclk) begin
        if (upd_en) begin
            hist_reg   <= hist_next;
            sorted_reg <= sorted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (clear) begin
            fill_reg <= '0;
        end else if (upd_en) begin
            fill_reg <= fill_next;
        end
    end

    assign sorted_o = sorted_reg;

endmodule

// ===== rtl/swm_median.sv =====
// Result stage of the median filter: picks the middle entries of the sorted
// window, adds them, and holds the beat in the output register. Depends on swm_pkg.
module swm_median (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  swm_pkg::cnt_t                  win_k,
    input  swm_pkg::sample_t               sorted_i [swm_pkg::WINDOW_MAX],
    output swm_pkg::med_status_t           status,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]  m_tdata
);

    logic              pend_reg;
    logic              out_valid_reg;
    swm_pkg::result_t  out_data_reg;
    logic              out_free;
    swm_pkg::idx_t     lo_idx;
    swm_pkg::idx_t     hi_idx;
    swm_pkg::sample_t  lo_val;
    swm_pkg::sample_t  hi_val;
    swm_pkg::result_t  median_x2;

    assign out_free = !out_valid_reg || m_tready;

    // Middle entries: equal for an odd window, adjacent for an even one
    assign lo_idx    = swm_pkg::idx_t'((win_k - swm_pkg::cnt_t'(1)) >> 1);
    assign hi_idx    = swm_pkg::idx_t'(win_k >> 1);
    assign lo_val    = sorted_i[lo_idx];
    assign hi_val    = sorted_i[hi_idx];
    assign median_x2 = swm_pkg::result_t'(lo_val) + swm_pkg::result_t'(hi_val);

    // The sorted window must hold while a median is pending and the output register cannot take it
    assign status.ready = !pend_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (load) begin
            pend_reg <= 1'b1;
        end else if (out_free) begin
            pend_reg <= 1'b0;
        end
    end

    // Advance the pending median into the output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= pend_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pend_reg && out_free) begin
            out_data_reg <= median_x2;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = swm_pkg::M_TDATA_W'($unsigned(out_data_reg));

endmodule

// ===== rtl/sliding_window_median_top.sv =====
// Top level of the sliding-window median filter: input register, window size
// register, and the window and result stages. Depends on swm_pkg, swm_window, swm_median.
//
// Streams one signed sample per beat and returns twice the median of the last
// window_size samples (0 acts as 1, above WINDOW_MAX acts as WINDOW_MAX). The
// filter is silent until the window has filled; every write to window_size
// empties it. One sample is taken per clock cycle while the result stream is
// not stalled; a result passes from its sample beat through the input register,
// the sort update of the window registers and the output register.
module sliding_window_median_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [swm_pkg::CFG_W-1:0]      cfg_wr_data,  // window_size
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [swm_pkg::S_TDATA_W-1:0]  s_tdata,      // [31:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [swm_pkg::M_TDATA_W-1:0]  m_tdata       // [32:0] median_x2, rest zero
);

    logic                 in_valid_reg;
    swm_pkg::sample_t     in_data_reg;
    swm_pkg::cnt_t        win_k_reg;
    logic                 fire;
    logic                 emit;
    swm_pkg::med_status_t med_status;
    swm_pkg::sample_t     sorted [swm_pkg::WINDOW_MAX];

    assign s_tready = !in_valid_reg || med_status.ready;
    assign fire     = in_valid_reg && med_status.ready;

    // Hold one input beat until the window can take it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= swm_pkg::sample_t'(s_tdata[swm_pkg::SAMPLE_BITS-1:0]);
        end
    end

    // Window size, stored already clamped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_k_reg <= swm_pkg::eff_size(swm_pkg::CFG_RESET);
        end else if (cfg_wr_en) begin
            win_k_reg <= swm_pkg::eff_size(cfg_wr_data);
        end
    end

    swm_window u_window (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (cfg_wr_en),
        .win_k    (win_k_reg),
        .upd_en   (fire),
        .sample   (in_data_reg),
        .emit     (emit),
        .sorted_o (sorted)
    );

    swm_median u_median (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (fire && emit),
        .win_k    (win_k_reg),
        .sorted_i (sorted),
        .status   (med_status),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== test/tb_top.sv =====
// Testbench for sliding_window_median_top: streams signed samples, predicts twice the
// window median in a scoreboard class and checks every result beat. Depends on swm_pkg.
// Also drives window_size writes between phases and random stalls on both streams.
module tb_top;

    typedef logic [swm_pkg::CFG_W-1:0] wsize_t;

    localparam swm_pkg::sample_t S_MIN = {1'b1, {(swm_pkg::SAMPLE_BITS-1){1'b0}}};
    localparam swm_pkg::sample_t S_MAX = {1'b0, {(swm_pkg::SAMPLE_BITS-1){1'b1}}};
    localparam int TOTAL_SAMPLES = 1350;
    localparam int CALM_TAIL     = 150;
    localparam int SETTLE_CYCLES = 8;

    // Window predictor and store of expected medians
    class median_tracker;
        swm_pkg::sample_t  sorted_win [swm_pkg::WINDOW_MAX];
        swm_pkg::sample_t  ring       [swm_pkg::WINDOW_MAX];
        int unsigned       fill;
        int unsigned       oldest;
        wsize_t            wsize;
        swm_pkg::result_t  expected_medians [$];
        int                errors;

        function new();
            wsize  = swm_pkg::CFG_RESET;
            fill   = 0;
            oldest = 0;
            errors = 0;
        endfunction

        task report(input string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        // Any write empties the window, even with an unchanged value
        function void set_window(input wsize_t v);
            wsize  = v;
            fill   = 0;
            oldest = 0;
        endfunction

        function int unsigned span();
            if (wsize == 0) begin
                return 1;
            end
            if (int'(wsize) > swm_pkg::WINDOW_MAX) begin
                return swm_pkg::WINDOW_MAX;
            end
            return wsize;
        endfunction

        // Insertion into sorted_win[0..n-1], keeping ascending order
        function void insert_sorted(input int unsigned n, input swm_pkg::sample_t s);
            int unsigned i;
            i = n;
            while (i > 0 && sorted_win[i-1] > s) begin
                sorted_win[i] = sorted_win[i-1];
                i--;
            end
            sorted_win[i] = s;
        endfunction

        function void note_sample(input swm_pkg::sample_t s);
            int unsigned      k;
            int unsigned      idx;
            int unsigned      i;
            bit               found;
            swm_pkg::sample_t leaving;
            swm_pkg::result_t med;
            k = span();
            if (fill < k) begin
                ring[(oldest + fill) % k] = s;
                insert_sorted(fill, s);
                fill++;
            end else begin
                // Drop exactly one sorted entry equal to the leaving sample
                leaving = ring[oldest];
                idx     = k - 1;
                found   = 0;
                for (i = 0; i < k; i++) begin
                    if (!found && sorted_win[i] == leaving) begin
                        idx   = i;
                        found = 1;
                    end
                end
                for (i = idx; i + 1 < k; i++) begin
                    sorted_win[i] = sorted_win[i+1];
                end
                insert_sorted(k - 1, s);
                ring[oldest] = s;
                oldest = (oldest + 1) % k;
            end
            if (fill == k) begin
                med = swm_pkg::result_t'(sorted_win[(k-1)/2])
                    + swm_pkg::result_t'(sorted_win[k/2]);
                expected_medians.insert(expected_medians.size(), med);
            end
        endfunction

        task check_median(input logic [swm_pkg::M_TDATA_W-1:0] tdata);
            swm_pkg::result_t got;
            swm_pkg::result_t want;
            got = tdata[swm_pkg::RES_BITS-1:0];
            if (expected_medians.size() == 0) begin
                report($sformatf("result %0d with nothing expected", got));
            end else begin
                want = expected_medians.pop_front();
                if (got !== want) begin
                    report($sformatf("median_x2 got %0d expected %0d", got, want));
                end
            end
        endtask

        function int pending();
            return expected_medians.size();
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_wr_en;
    wsize_t                          cfg_wr_data;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [swm_pkg::S_TDATA_W-1:0]   s_tdata;    // [31:0] sample
    logic                            m_tvalid;
    logic                            m_tready;
    logic [swm_pkg::M_TDATA_W-1:0]   m_tdata;    // [32:0] median_x2, rest zero

    median_tracker sb = new();
    bit            calm;
    int            samples_sent;

    sliding_window_median_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard limit on run length
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Watch both streams for accepted beats
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_sample(swm_pkg::sample_t'(s_tdata[swm_pkg::SAMPLE_BITS-1:0]));
            end
            if (m_tvalid && m_tready) begin
                sb.check_median(m_tdata);
            end
        end
    end

    // Result side backpressure: short stalls, short and long ready stretches
    initial begin
        int r;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            r = $urandom_range(0, 9);
            if (calm) begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end else if (r < 3) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else if (r == 3) begin
                m_tready <= 1'b1;
                repeat ($urandom_range(100, 300)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    // Offer one sample and hold it until the beat is taken
    task automatic send_sample(input swm_pkg::sample_t v);
        s_tvalid <= 1'b1;
        s_tdata  <= swm_pkg::S_TDATA_W'($unsigned(v));
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    // Idle the input stream with noise on the data lines
    task automatic pause_sender(input int cycles);
        s_tvalid <= 1'b0;
        s_tdata  <= swm_pkg::S_TDATA_W'($urandom);
        repeat (cycles) @(posedge aclk);
    endtask

    // Stop sending and wait for every expected median
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Write window_size once the block has gone quiet
    task automatic write_window(input wsize_t v);
        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_window(v);
    endtask

    // Stimulus
    initial begin
        int               plan [7] = '{16, 31, 1, 17, 0, 15, 2};
        int               phase;
        int               count;
        int               gap_pct;
        int               r;
        swm_pkg::sample_t prev;
        swm_pkg::sample_t v;

        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        aresetn      <= 1'b0;
        calm         = 0;
        samples_sent = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset window of three: extremes, sign boundary, duplicates
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(swm_pkg::sample_t'(0));
        send_sample(swm_pkg::sample_t'(-1));
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);
        send_sample(swm_pkg::sample_t'(1));
        send_sample(swm_pkg::sample_t'(1));
        send_sample(swm_pkg::sample_t'(1));

        // Rewrite of the same size clears the window; partial fill gives nothing
        write_window(5'd3);
        send_sample(swm_pkg::sample_t'(7));
        send_sample(swm_pkg::sample_t'(-7));

        // Even window: sums at both ends of the result range
        write_window(5'd2);
        send_sample(S_MAX);
        send_sample(S_MAX);
        send_sample(S_MIN);
        send_sample(S_MIN);

        // Size zero acts as one
        write_window(5'd0);
        send_sample(S_MIN);
        send_sample(S_MAX);
        send_sample(swm_pkg::sample_t'(-1));

        // Random phases over many window settings
        phase = 0;
        prev  = '0;
        while (samples_sent < TOTAL_SAMPLES) begin
            if (phase < 7) begin
                write_window(wsize_t'(plan[phase]));
            end else if ($urandom_range(0, 3) == 0) begin
                write_window(wsize_t'($urandom_range(0, 31)));
            end else begin
                write_window(wsize_t'($urandom_range(1, 6)));
            end
            gap_pct = $urandom_range(0, 3) * 10;
            count   = $urandom_range(20, 120);
            for (int n = 0; n < count && samples_sent < TOTAL_SAMPLES; n++) begin
                if (samples_sent >= TOTAL_SAMPLES - CALM_TAIL) begin
                    calm = 1;
                end
                // Hold off once until the block has emptied
                if (phase == 2 && n == count / 2) begin
                    drain();
                end
                if (!calm && $urandom_range(0, 99) < gap_pct) begin
                    pause_sender($urandom_range(1, 14));
                end
                r = $urandom_range(0, 9);
                if (r < 5) begin
                    v = swm_pkg::sample_t'($urandom);
                end else if (r < 7) begin
                    v = swm_pkg::sample_t'(int'($urandom_range(0, 8)) - 4);
                end else if (r == 7) begin
                    case ($urandom_range(0, 3))
                        0: v = S_MIN;
                        1: v = S_MAX;
                        2: v = swm_pkg::sample_t'(0);
                        default: v = swm_pkg::sample_t'(-1);
                    endcase
                end else begin
                    v = prev;
                end
                prev = v;
                send_sample(v);
            end
            phase++;
        end

        // Wind down and settle
        drain();
        repeat (20) @(posedge aclk);
        if (sb.pending() != 0) begin
            sb.report($sformatf("%0d medians never arrived", sb.pending()));
        end
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
